[rtl/hrm_pkg.sv]
package hrm_pkg;

	localparam int PIXEL_COUNT_LOG2_DEF = 22;
	localparam int CORDIC_STAGES_DEF    = 16;
	localparam int EPS_W                = 23;
	localparam int LEVEL_W              = 24;
	localparam int INT_W                = 8;
	localparam int H_W                  = 17;
	localparam int MEAN_W               = 16;
	localparam int Z_W                  = 34;
	localparam int X_W                  = 28;
	localparam logic [EPS_W-1:0] EPS_RESET = 23'd1;
	localparam logic [H_W-1:0] H_ONE  = 17'd65536;
	localparam logic [H_W-1:0] H_HALF = 17'd32768;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_DIVIDE,
		ST_OUTPUT
	} state_t;

	typedef struct packed {
		logic start_div;
		logic clear_acc;
	} ctrl_cmd_t;

	typedef struct packed {
		logic frame_done;
		logic div_done;
		logic pipe_empty;
	} ctrl_sts_t;

	function automatic logic [Z_W-1:0] angle(input int i);
		logic [Z_W-1:0] a;
		case (i)
			0: a = 34'd536870912;
			1: a = 34'd316933406;
			2: a = 34'd167458907;
			3: a = 34'd85004756;
			4: a = 34'd42667331;
			5: a = 34'd21354465;
			6: a = 34'd10679838;
			7: a = 34'd5340245;
			8: a = 34'd2670163;
			9: a = 34'd1335087;
			10: a = 34'd667544;
			11: a = 34'd333772;
			12: a = 34'd166886;
			13: a = 34'd83443;
			14: a = 34'd41722;
			15: a = 34'd20861;
			16: a = 34'd10430;
			17: a = 34'd5215;
			18: a = 34'd2608;
			19: a = 34'd1304;
			20: a = 34'd652;
			21: a = 34'd326;
			22: a = 34'd163;
			23: a = 34'd81;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

[rtl/hrm_ctrl.sv]
module hrm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  hrm_pkg::ctrl_sts_t sts,
	input  logic               out_taken,
	output hrm_pkg::ctrl_cmd_t cmd,
	output logic               in_ready,
	output logic               out_valid
);

	hrm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrm_pkg::ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd.start_div = 1'b0;
		cmd.clear_acc = 1'b0;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		case (state_q)
			hrm_pkg::ST_ACCUM: begin
				in_ready = !sts.frame_done;
				if (sts.frame_done && sts.pipe_empty) begin
					cmd.start_div = 1'b1;
					state_d       = hrm_pkg::ST_DIVIDE;
				end
			end
			hrm_pkg::ST_DIVIDE: begin
				if (sts.div_done) begin
					state_d = hrm_pkg::ST_OUTPUT;
				end
			end
			hrm_pkg::ST_OUTPUT: begin
				out_valid = 1'b1;
				if (out_taken) begin
					cmd.clear_acc = 1'b1;
					state_d       = hrm_pkg::ST_ACCUM;
				end
			end
			default: begin
				state_d = hrm_pkg::ST_ACCUM;
			end
		endcase
	end

endmodule

[rtl/hrm_cordic.sv]
module hrm_cordic #(
	parameter int CORDIC_STAGES = hrm_pkg::CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [hrm_pkg::INT_W-1:0]     in_int,
	input  logic signed [hrm_pkg::LEVEL_W-1:0] in_level,
	input  logic [hrm_pkg::EPS_W-1:0]     eps,
	output logic                          out_valid,
	output logic [hrm_pkg::INT_W-1:0]     out_int,
	output logic [hrm_pkg::H_W-1:0]       out_h,
	output logic                          busy
);

	localparam int N = CORDIC_STAGES;
	localparam int XW = hrm_pkg::X_W;
	localparam int ZW = hrm_pkg::Z_W;

	logic                 v_q    [N+1];
	logic                 zero_q [N+1];
	logic [hrm_pkg::INT_W-1:0] int_q [N+1];
	logic signed [XW-1:0] x_q [N+1];
	logic signed [XW-1:0] y_q [N+1];
	logic signed [ZW-1:0] z_q [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else begin
			v_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		zero_q[0] <= (in_level == '0);
		int_q[0]  <= in_int;
		x_q[0]    <= XW'($signed({1'b0, eps}));
		y_q[0]    <= XW'(in_level);
		z_q[0]    <= '0;
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic signed [XW-1:0] dx, dy;
		assign dx = y_q[i] >>> i;
		assign dy = x_q[i] >>> i;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else begin
				v_q[i+1] <= v_q[i];
			end
		end
		always_ff @(posedge clk) begin
			zero_q[i+1] <= zero_q[i];
			int_q[i+1]  <= int_q[i];
			if (!y_q[i][XW-1]) begin
				x_q[i+1] <= x_q[i] + dx;
				y_q[i+1] <= y_q[i] - dy;
				z_q[i+1] <= z_q[i] + $signed(hrm_pkg::angle(i));
			end else begin
				x_q[i+1] <= x_q[i] - dx;
				y_q[i+1] <= y_q[i] + dy;
				z_q[i+1] <= z_q[i] - $signed(hrm_pkg::angle(i));
			end
		end
	end

	logic signed [ZW-1:0] t;
	logic [ZW-1:0] ts;
	assign t  = z_q[N] + ZW'(64'sd1073741824);
	assign ts = ZW'(t >>> 15);

	always_comb begin
		if (zero_q[N]) begin
			out_h = hrm_pkg::H_HALF;
		end else if (t[ZW-1]) begin
			out_h = '0;
		end else if (ts > ZW'(hrm_pkg::H_ONE)) begin
			out_h = hrm_pkg::H_ONE;
		end else begin
			out_h = ts[hrm_pkg::H_W-1:0];
		end
	end

	assign out_valid = v_q[N];
	assign out_int   = int_q[N];

	always_comb begin
		busy = 1'b0;
		for (int k = 0; k <= N; k++) begin
			busy = busy | v_q[k];
		end
	end

endmodule

[rtl/hrm_datapath.sv]
module hrm_datapath #(
	parameter int PIXEL_COUNT_LOG2 = hrm_pkg::PIXEL_COUNT_LOG2_DEF,
	parameter int CORDIC_STAGES    = hrm_pkg::CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hrm_pkg::ctrl_cmd_t            cmd,
	output hrm_pkg::ctrl_sts_t            sts,
	input  logic                          in_fire,
	input  logic [hrm_pkg::INT_W-1:0]     in_int,
	input  logic signed [hrm_pkg::LEVEL_W-1:0] in_level,
	input  logic                          in_last,
	input  logic                          cfg_we,
	input  logic [hrm_pkg::EPS_W-1:0]     cfg_data,
	output logic [hrm_pkg::MEAN_W-1:0]    pos_mean,
	output logic [hrm_pkg::MEAN_W-1:0]    neg_mean,
	output logic                          pos_empty,
	output logic                          neg_empty
);

	localparam int WB  = PIXEL_COUNT_LOG2 + 17;
	localparam int WDB = PIXEL_COUNT_LOG2 + 25;
	localparam int NW  = WDB + 8;
	localparam int CW  = $clog2(NW + 1);

	logic [hrm_pkg::EPS_W-1:0] eps_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= hrm_pkg::EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_data;
		end
	end

	logic                      c_valid, busy;
	logic [hrm_pkg::INT_W-1:0] c_int;
	logic [hrm_pkg::H_W-1:0]   c_h;

	hrm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
		.clk, .arst_n,
		.in_valid (in_fire),
		.in_int, .in_level,
		.eps      (eps_q),
		.out_valid(c_valid),
		.out_int  (c_int),
		.out_h    (c_h),
		.busy
	);

	// One product stage ahead of the accumulators.
	logic                  v_s1;
	logic [hrm_pkg::H_W-1:0] h_s1, hn_s1;
	logic [hrm_pkg::H_W+hrm_pkg::INT_W-1:0] ph_s1, pn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= c_valid;
		end
	end

	always_ff @(posedge clk) begin
		h_s1    <= c_h;
		hn_s1   <= hrm_pkg::H_ONE - c_h;
		ph_s1   <= c_int * c_h;
		pn_s1   <= c_int * (hrm_pkg::H_ONE - c_h);
	end

	logic [WDB-1:0] pws_q, nws_q;
	logic [WB-1:0]  pw_q, nw_q;
	logic           frame_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pws_q        <= '0;
			nws_q        <= '0;
			pw_q         <= '0;
			nw_q         <= '0;
			frame_done_q <= 1'b0;
		end else if (cmd.clear_acc) begin
			pws_q        <= '0;
			nws_q        <= '0;
			pw_q         <= '0;
			nw_q         <= '0;
			frame_done_q <= 1'b0;
		end else begin
			if (v_s1) begin
				pws_q <= pws_q + WDB'(ph_s1);
				nws_q <= nws_q + WDB'(pn_s1);
				pw_q  <= pw_q + WB'(h_s1);
				nw_q  <= nw_q + WB'(hn_s1);
			end
			if (in_fire && in_last) begin
				frame_done_q <= 1'b1;
			end
		end
	end

	// Two restoring dividers, one quotient bit per cycle.
	logic [NW-1:0] pq_q, nq_q, pr_q, nr_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [NW:0]   ptr, ntr;

	assign ptr = {pr_q, pq_q[NW-1]} - {1'b0, (NW)'(pw_q)};
	assign ntr = {nr_q, nq_q[NW-1]} - {1'b0, (NW)'(nw_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.start_div) begin
			run_q <= 1'b1;
			cnt_q <= CW'(NW);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			pq_q <= {pws_q, 8'd0};
			nq_q <= {nws_q, 8'd0};
			pr_q <= '0;
			nr_q <= '0;
		end else if (run_q) begin
			if (!ptr[NW]) begin
				pr_q <= ptr[NW-1:0];
				pq_q <= {pq_q[NW-2:0], 1'b1};
			end else begin
				pr_q <= {pr_q[NW-2:0], pq_q[NW-1]};
				pq_q <= {pq_q[NW-2:0], 1'b0};
			end
			if (!ntr[NW]) begin
				nr_q <= ntr[NW-1:0];
				nq_q <= {nq_q[NW-2:0], 1'b1};
			end else begin
				nr_q <= {nr_q[NW-2:0], nq_q[NW-1]};
				nq_q <= {nq_q[NW-2:0], 1'b0};
			end
		end
	end

	assign pos_empty = (pw_q == '0);
	assign neg_empty = (nw_q == '0);
	assign pos_mean  = pos_empty ? '0 : (|pq_q[NW-1:16] ? 16'hffff : pq_q[15:0]);
	assign neg_mean  = neg_empty ? '0 : (|nq_q[NW-1:16] ? 16'hffff : nq_q[15:0]);

	assign sts.frame_done = frame_done_q;
	assign sts.div_done   = run_q && (cnt_q == CW'(1));
	assign sts.pipe_empty = !busy && !v_s1;

endmodule

[rtl/heaviside_region_means.sv]
// Heaviside-weighted region means of a pixel stream.
// Requests on s_axis: tdata = intensity [7:0], level_value [31:8] (signed
// Q15.8); tlast marks the last pixel of a frame. Pixels are taken one per
// clock until the last one of a frame is accepted.
// After the last pixel, s_axis_tready stays low while the CORDIC pipeline
// and one product stage drain and two bit-serial dividers run, one quotient
// bit per cycle, for PIXEL_COUNT_LOG2 + 33 quotient bits.
// One result then appears on m_axis: tdata = positive_side_mean [15:0],
// negative_side_mean [31:16]; tuser = positive_side_empty [0],
// negative_side_empty [1]. The result holds until m_axis_tready is high, the
// accumulators then clear and the next frame may start.
// Within a frame, pixels are taken one per cycle while s_axis_tready is high;
// between frames the block waits for the pipeline to drain, for the dividers
// and for the result handshake. epsilon is written through cfg_we/cfg_data by
// the user, only while the block is idle; the block itself does not enforce this.
// Reset clears the accumulators and sets epsilon to 1.
module heaviside_region_means #(
	parameter int PIXEL_COUNT_LOG2 = hrm_pkg::PIXEL_COUNT_LOG2_DEF,
	parameter int CORDIC_STAGES    = hrm_pkg::CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // intensity, level_value
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // positive_side_mean, negative_side_mean
	output logic [1:0]  m_axis_tuser,  // positive_side_empty, negative_side_empty
	input  logic        cfg_we,
	input  logic [22:0] cfg_data
);

	hrm_pkg::ctrl_cmd_t cmd;
	hrm_pkg::ctrl_sts_t sts;
	logic               in_fire;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	hrm_ctrl u_ctrl (
		.clk, .arst_n,
		.sts,
		.out_taken(m_axis_tvalid && m_axis_tready),
		.cmd,
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid)
	);

	hrm_datapath #(
		.PIXEL_COUNT_LOG2(PIXEL_COUNT_LOG2),
		.CORDIC_STAGES   (CORDIC_STAGES)
	) u_dp (
		.clk, .arst_n,
		.cmd,
		.sts,
		.in_fire,
		.in_int   (s_axis_tdata[7:0]),
		.in_level (s_axis_tdata[31:8]),
		.in_last  (s_axis_tlast),
		.cfg_we,
		.cfg_data,
		.pos_mean (m_axis_tdata[15:0]),
		.neg_mean (m_axis_tdata[31:16]),
		.pos_empty(m_axis_tuser[0]),
		.neg_empty(m_axis_tuser[1])
	);

endmodule

[rtl/hrm_checker.sv]
module hrm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("pixel accepted while result pending");

	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("pixel accepted after frame end");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[15:0] == 16'd0)
		else $error("empty side with nonzero mean");

endmodule

bind heaviside_region_means hrm_checker u_chk (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tlast,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
